FILE: rtl/ftl_pkg.sv
// ----------------------------------------------------------------------------
// ftl_pkg
// shared widths, constants and types of the one-percent-low frame rate monitor
// ----------------------------------------------------------------------------
package ftl_pkg;

  localparam int unsigned SAMPLE_W = 20;
  localparam int unsigned FPS_W    = 28;
  localparam int unsigned WIN_W    = 10;

  // one-percent bucket: k grows by one every hundred samples
  localparam int unsigned PCT_W    = 7;
  localparam logic [PCT_W-1:0] PCT_LAST = 7'd99;

  // 1e6 us per s times 256 for the q8 rate
  localparam logic [FPS_W-1:0] RATE_NUM = 28'd256000000;

  typedef struct packed {
    logic clear;
    logic insert;
    logic shift;
  } topk_ctrl_t;

endpackage

FILE: rtl/ftl_in_if.sv
// ----------------------------------------------------------------------------
// ftl_in_if
// frame time input channel, valid/ready
// ----------------------------------------------------------------------------
interface ftl_in_if;
  logic                         valid;
  logic                         ready;
  logic [ftl_pkg::SAMPLE_W-1:0] frame_us;

  modport source (output valid, output frame_us, input ready);
  modport sink (input valid, input frame_us, output ready);
endinterface

FILE: rtl/ftl_out_if.sv
// ----------------------------------------------------------------------------
// ftl_out_if
// one-percent-low result channel, valid/ready
// ----------------------------------------------------------------------------
interface ftl_out_if;
  logic                         valid;
  logic                         ready;
  logic [ftl_pkg::FPS_W-1:0]    low_fps_q8;
  logic [ftl_pkg::SAMPLE_W-1:0] worst_mean_us;
  logic [ftl_pkg::WIN_W-1:0]    window_count;

  modport source (output valid, output low_fps_q8, output worst_mean_us,
                  output window_count, input ready);
  modport sink (input valid, input low_fps_q8, input worst_mean_us,
                input window_count, output ready);
endinterface

FILE: rtl/ftl_ram.sv
// ----------------------------------------------------------------------------
// ftl_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module ftl_ram #(
  parameter int unsigned WIDTH = 20,
  parameter int unsigned DEPTH = 512
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/ftl_div.sv
// ----------------------------------------------------------------------------
// ftl_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ftl_div #(
  parameter int unsigned DIV_W = 28
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [DIV_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DIV_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = (DIV_W > 1) ? $clog2(DIV_W) : 1;

  logic [DIV_W:0]   rem_q;
  logic [DIV_W-1:0] quo_q;
  logic [DIV_W-1:0] dvs_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [DIV_W:0]   rem_sh;
  logic [DIV_W+1:0] diff;

  assign rem_sh = {rem_q[DIV_W-1:0], quo_q[DIV_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DIV_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      if (!diff[DIV_W+1]) begin
        rem_q <= diff[DIV_W:0];
        quo_q <= {quo_q[DIV_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[DIV_W-2:0], 1'b0};
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: rtl/ftl_topk.sv
// ----------------------------------------------------------------------------
// ftl_topk
// sorted row of cells keeping the largest samples seen in one ring walk
// ----------------------------------------------------------------------------
module ftl_topk #(
  parameter int unsigned ENTRIES = 6
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ftl_pkg::topk_ctrl_t          ctrl_i,
  input  logic [ftl_pkg::SAMPLE_W-1:0] sample_i,
  output logic [ftl_pkg::SAMPLE_W-1:0] head_o
);

  logic [ftl_pkg::SAMPLE_W-1:0] val_q   [ENTRIES];
  logic [ftl_pkg::SAMPLE_W-1:0] ins_val [ENTRIES];
  logic [ftl_pkg::SAMPLE_W-1:0] sh_val  [ENTRIES];
  logic [ENTRIES-1:0]           vld_q;
  logic [ENTRIES-1:0]           ins_vld;
  logic [ENTRIES-1:0]           sh_vld;
  logic [ENTRIES-1:0]           above;

  for (genvar j = 0; j < ENTRIES; j++) begin : g_cell
    // new sample belongs at or above this cell
    assign above[j] = !vld_q[j] || (val_q[j] < sample_i);
    if (j == 0) begin : g_first
      assign ins_val[j] = above[j] ? sample_i : val_q[j];
      assign ins_vld[j] = above[j] | vld_q[j];
    end else begin : g_rest
      assign ins_val[j] = !above[j] ? val_q[j] :
                          (above[j-1] ? val_q[j-1] : sample_i);
      assign ins_vld[j] = !above[j] ? vld_q[j] :
                          (above[j-1] ? vld_q[j-1] : 1'b1);
    end
    if (j == ENTRIES - 1) begin : g_last
      assign sh_val[j] = val_q[j];
      assign sh_vld[j] = 1'b0;
    end else begin : g_mid
      assign sh_val[j] = val_q[j+1];
      assign sh_vld[j] = vld_q[j+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ctrl_i.clear) begin
      vld_q <= '0;
    end else if (ctrl_i.insert) begin
      vld_q <= ins_vld;
    end else if (ctrl_i.shift) begin
      vld_q <= sh_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.insert) begin
      val_q <= ins_val;
    end else if (ctrl_i.shift) begin
      val_q <= sh_val;
    end
  end

  assign head_o = val_q[0];

endmodule

FILE: rtl/frame_time_one_percent_low.sv
// ----------------------------------------------------------------------------
// frame_time_one_percent_low
// one-percent-low frame rate monitor over a ring of recent frame times
//
//   channel   dir   fields                                       transaction
//   in_i      in    frame_us                                     valid & ready
//   out_o     out   low_fps_q8, worst_mean_us, window_count      valid & ready
//
// each item walks the ring through the single ram read port and then runs the
// bit-serial divider, once for the mean and, unless the mean is zero, once
// for the rate
// one item is in work at a time; the next is taken once the result is
// registered, even while that result still waits on out_o.ready
// no clearing pass after reset: ring entries are read only after being written
// ----------------------------------------------------------------------------
module frame_time_one_percent_low #(
  parameter int unsigned HISTORY_DEPTH = 512
) (
  input logic        clk_i,
  input logic        rst_ni,
  ftl_in_if.sink     in_i,
  ftl_out_if.source  out_o
);

  localparam int unsigned TOP_MAX = (HISTORY_DEPTH + 99) / 100;
  localparam int unsigned ADDR_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned CNT_W   = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned K_W     = $clog2(TOP_MAX + 1);
  localparam int unsigned SUM_W   = ftl_pkg::SAMPLE_W + K_W;
  localparam int unsigned DIV_W   = (SUM_W > ftl_pkg::FPS_W) ? SUM_W : ftl_pkg::FPS_W;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SCAN   = 4'd1;
  localparam logic [3:0] S_FLUSH  = 4'd2;
  localparam logic [3:0] S_DRAIN  = 4'd3;
  localparam logic [3:0] S_MEANGO = 4'd4;
  localparam logic [3:0] S_MEAN   = 4'd5;
  localparam logic [3:0] S_FPSGO  = 4'd6;
  localparam logic [3:0] S_FPS    = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  logic [3:0]                   state_q, state_d;
  logic [ADDR_W-1:0]            slot_q, slot_d;
  logic [CNT_W-1:0]             count_q, count_d;
  logic [ftl_pkg::PCT_W-1:0]    pct_q, pct_d;
  logic [K_W-1:0]               k_q, k_d;
  logic [ADDR_W-1:0]            rd_idx_q, rd_idx_d;
  logic                         rd_pend_q, rd_pend_d;
  logic [K_W-1:0]               drain_q, drain_d;
  logic [SUM_W-1:0]             sum_q, sum_d;
  logic [ftl_pkg::SAMPLE_W-1:0] mean_q, mean_d;
  logic [ftl_pkg::FPS_W-1:0]    fps_q, fps_d;
  logic                         out_vld_q, out_vld_d;
  logic [ftl_pkg::FPS_W-1:0]    out_fps_q, out_fps_d;
  logic [ftl_pkg::SAMPLE_W-1:0] out_mean_q, out_mean_d;
  logic [ftl_pkg::WIN_W-1:0]    out_win_q, out_win_d;

  logic                         in_acc;
  logic                         out_free;
  logic [ftl_pkg::SAMPLE_W-1:0] rd_data;
  logic [ftl_pkg::SAMPLE_W-1:0] head;
  ftl_pkg::topk_ctrl_t          topk_ctrl;
  logic                         div_start;
  logic [DIV_W-1:0]             div_num;
  logic [DIV_W-1:0]             div_den;
  logic                         div_done;
  logic [DIV_W-1:0]             div_q;
  logic [31:0]                  count_ext;

  assign in_acc    = in_i.valid && in_i.ready;
  assign out_free  = !out_vld_q || out_o.ready;
  assign count_ext = 32'(count_q);

  ftl_ram #(
    .WIDTH (ftl_pkg::SAMPLE_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (in_acc),
    .waddr_i (slot_q),
    .wdata_i (in_i.frame_us),
    .raddr_i (rd_idx_q),
    .rdata_o (rd_data)
  );

  ftl_topk #(
    .ENTRIES (TOP_MAX)
  ) u_topk (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (topk_ctrl),
    .sample_i (rd_data),
    .head_o   (head)
  );

  ftl_div #(
    .DIV_W (DIV_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  always_comb begin
    state_d    = state_q;
    slot_d     = slot_q;
    count_d    = count_q;
    pct_d      = pct_q;
    k_d        = k_q;
    rd_idx_d   = rd_idx_q;
    rd_pend_d  = 1'b0;
    drain_d    = drain_q;
    sum_d      = sum_q;
    mean_d     = mean_q;
    fps_d      = fps_q;
    out_vld_d  = out_vld_q;
    out_fps_d  = out_fps_q;
    out_mean_d = out_mean_q;
    out_win_d  = out_win_q;
    topk_ctrl  = '{clear: 1'b0, insert: rd_pend_q, shift: 1'b0};
    div_start  = 1'b0;
    div_num    = DIV_W'(sum_q);
    div_den    = DIV_W'(k_q);

    if (out_vld_q && out_o.ready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          slot_d = (slot_q == ADDR_W'(HISTORY_DEPTH - 1)) ? '0 : slot_q + 1'b1;
          if (count_q != CNT_W'(HISTORY_DEPTH)) begin
            count_d = count_q + 1'b1;
            if (pct_q == '0) begin
              k_d = k_q + 1'b1;
            end
            pct_d = (pct_q == ftl_pkg::PCT_LAST) ? '0 : pct_q + 1'b1;
          end
          topk_ctrl.clear = 1'b1;
          rd_idx_d = '0;
          state_d  = S_SCAN;
        end
      end
      S_SCAN: begin
        rd_pend_d = 1'b1;
        if (CNT_W'(rd_idx_q) == count_q - 1'b1) begin
          state_d = S_FLUSH;
        end else begin
          rd_idx_d = rd_idx_q + 1'b1;
        end
      end
      S_FLUSH: begin
        drain_d = k_q;
        sum_d   = '0;
        state_d = S_DRAIN;
      end
      S_DRAIN: begin
        topk_ctrl.shift = 1'b1;
        sum_d   = sum_q + SUM_W'(head);
        drain_d = drain_q - 1'b1;
        if (drain_q == K_W'(1)) begin
          state_d = S_MEANGO;
        end
      end
      S_MEANGO: begin
        div_start = 1'b1;
        state_d   = S_MEAN;
      end
      S_MEAN: begin
        if (div_done) begin
          mean_d = div_q[ftl_pkg::SAMPLE_W-1:0];
          if (div_q[ftl_pkg::SAMPLE_W-1:0] == '0) begin
            fps_d   = '0;
            state_d = S_DONE;
          end else begin
            state_d = S_FPSGO;
          end
        end
      end
      S_FPSGO: begin
        div_start = 1'b1;
        div_num   = DIV_W'(ftl_pkg::RATE_NUM);
        div_den   = DIV_W'(mean_q);
        state_d   = S_FPS;
      end
      S_FPS: begin
        if (div_done) begin
          fps_d   = div_q[ftl_pkg::FPS_W-1:0];
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_fps_d  = fps_q;
          out_mean_d = mean_q;
          out_win_d  = count_ext[ftl_pkg::WIN_W-1:0];
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      slot_q    <= '0;
      count_q   <= '0;
      pct_q     <= '0;
      k_q       <= '0;
      rd_pend_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      slot_q    <= slot_d;
      count_q   <= count_d;
      pct_q     <= pct_d;
      k_q       <= k_d;
      rd_pend_q <= rd_pend_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q   <= rd_idx_d;
    drain_q    <= drain_d;
    sum_q      <= sum_d;
    mean_q     <= mean_d;
    fps_q      <= fps_d;
    out_fps_q  <= out_fps_d;
    out_mean_q <= out_mean_d;
    out_win_q  <= out_win_d;
  end

  assign in_i.ready          = (state_q == S_IDLE);
  assign out_o.valid         = out_vld_q;
  assign out_o.low_fps_q8    = out_fps_q;
  assign out_o.worst_mean_us = out_mean_q;
  assign out_o.window_count  = out_win_q;

  // window fill never passes the ring depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(HISTORY_DEPTH))
    else $error("fill count beyond ring depth");

  // k tracks ceil(count / 100) and stays within the cell row
  a_k_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) |-> ((k_q != '0) && (k_q <= K_W'(TOP_MAX))))
    else $error("k out of range");

  // a nonzero mean of at most 20 bits always gives a nonzero rate
  a_rate_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_done && (state_q == S_FPS)) |-> (div_q != '0))
    else $error("zero rate from nonzero mean");

  // a registered result has zero rate exactly when its mean is zero
  a_out_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> ((out_mean_q == '0) == (out_fps_q == '0)))
    else $error("rate and mean disagree on zero");

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the one-percent-low frame rate monitor: frame times go in through a
// bursty valid/ready driver, every transaction is run through a local model of
// the sample ring and the k-largest mean, and each result taken under random
// receiver stalls is compared field by field against the oldest prediction
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned SAMPLE_W    = ftl_pkg::SAMPLE_W;
  localparam int unsigned FPS_W       = ftl_pkg::FPS_W;
  localparam int unsigned WIN_W       = ftl_pkg::WIN_W;

  localparam int unsigned DEPTH       = 512;
  localparam int unsigned PCT_SPAN    = 100;
  localparam int unsigned TOP_K_MAX   = (DEPTH + PCT_SPAN - 1) / PCT_SPAN;
  localparam int unsigned HIST_IDX_W  = $clog2(DEPTH);
  localparam int unsigned TOP_IDX_W   = $clog2(TOP_K_MAX);
  localparam int unsigned N_RANDOM    = 580;
  localparam int unsigned TAIL_CYCLES = 800;
  localparam int unsigned CYCLE_LIMIT = 4000000;

  typedef struct packed {
    logic [FPS_W-1:0]    low_fps_q8;
    logic [SAMPLE_W-1:0] worst_mean_us;
    logic [WIN_W-1:0]    window_count;
  } low_result_t;

  logic clk_i = 1'b0;
  logic rst_n;

  ftl_in_if  frame_ch ();
  ftl_out_if result_ch ();

  frame_time_one_percent_low #(
    .HISTORY_DEPTH(DEPTH)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_n),
    .in_i  (frame_ch),
    .out_o (result_ch)
  );

  // local copy of the frame history
  logic [SAMPLE_W-1:0] frame_hist [DEPTH];
  int unsigned         hist_slot = 0;
  int unsigned         hist_fill = 0;

  logic [SAMPLE_W-1:0] frames_to_send [$];
  low_result_t         expected_lows [$];
  low_result_t         oldest_low;

  int unsigned frames_taken = 0;
  int unsigned frames_total;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned calm_left = 0;

  function automatic low_result_t predict_one_percent_low(input logic [SAMPLE_W-1:0] us);
    logic [SAMPLE_W-1:0] largest [TOP_K_MAX];
    logic [SAMPLE_W-1:0] v;
    int unsigned         k;
    int unsigned         n_held;
    int                  pos;
    bit                  keep;
    longint unsigned     sum;
    longint unsigned     mean;
    low_result_t         r;
    frame_hist[HIST_IDX_W'(hist_slot)] = us;
    hist_slot = (hist_slot + 1) % DEPTH;
    if (hist_fill < DEPTH) hist_fill++;
    k = (hist_fill + PCT_SPAN - 1) / PCT_SPAN;
    if (k < 1) k = 1;
    if (k > hist_fill) k = hist_fill;
    if (k > TOP_K_MAX) k = TOP_K_MAX;
    // running k-largest list, descending
    n_held = 0;
    for (int i = 0; i < hist_fill; i++) begin
      v = frame_hist[HIST_IDX_W'(i)];
      keep = 1'b1;
      if (n_held < k) begin
        pos = n_held;
        n_held++;
      end else if (v > largest[TOP_IDX_W'(k-1)]) begin
        pos = k - 1;
      end else begin
        keep = 1'b0;
      end
      if (keep) begin
        while (pos > 0 && largest[TOP_IDX_W'(pos-1)] < v) begin
          largest[TOP_IDX_W'(pos)] = largest[TOP_IDX_W'(pos-1)];
          pos--;
        end
        largest[TOP_IDX_W'(pos)] = v;
      end
    end
    sum = 0;
    for (int i = 0; i < n_held; i++) sum += largest[TOP_IDX_W'(i)];
    mean = sum / k;
    r.worst_mean_us = mean[SAMPLE_W-1:0];
    r.low_fps_q8    = (mean != 0) ? FPS_W'(longint'(ftl_pkg::RATE_NUM) / mean) : '0;
    r.window_count  = hist_fill[WIN_W-1:0];
    return r;
  endfunction

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // driver, bursts with random gaps
  always @(posedge clk_i) begin
    if (!rst_n) begin
      frame_ch.valid <= 1'b0;
    end else begin
      if (frame_ch.valid && frame_ch.ready) begin
        expected_lows.push_back(predict_one_percent_low(frame_ch.frame_us));
        frames_taken++;
      end
      if (!frame_ch.valid || frame_ch.ready) begin
        if (gap_left > 0 || frames_to_send.size() == 0) begin
          if (gap_left > 0) gap_left--;
          frame_ch.valid <= 1'b0;
        end else begin
          frame_ch.valid    <= 1'b1;
          frame_ch.frame_us <= frames_to_send.pop_front();
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 12);
            gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 700)
                                                     : $urandom_range(0, 4);
          end
        end
      end
    end
  end

  // receiver stalls, short and long, with calm stretches
  always @(posedge clk_i) begin
    if (!rst_n) begin
      result_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= 1'b1;
      if (calm_left > 0) begin
        calm_left--;
      end else if ($urandom_range(0, 7) == 0) begin
        stall_left = ($urandom_range(0, 15) == 0) ? $urandom_range(50, 600)
                                                  : $urandom_range(1, 12);
        if ($urandom_range(0, 15) == 0) calm_left = $urandom_range(500, 3000);
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_n && result_ch.valid && result_ch.ready) begin
      if (expected_lows.size() == 0) begin
        $display("%0t unexpected transaction: fps %0d mean %0d count %0d", $time,
                 result_ch.low_fps_q8, result_ch.worst_mean_us, result_ch.window_count);
        error_count++;
      end else begin
        oldest_low = expected_lows.pop_front();
        if (result_ch.low_fps_q8 !== oldest_low.low_fps_q8) begin
          $display("%0t low_fps_q8 expected %0d actual %0d", $time,
                   oldest_low.low_fps_q8, result_ch.low_fps_q8);
          error_count++;
        end
        if (result_ch.worst_mean_us !== oldest_low.worst_mean_us) begin
          $display("%0t worst_mean_us expected %0d actual %0d", $time,
                   oldest_low.worst_mean_us, result_ch.worst_mean_us);
          error_count++;
        end
        if (result_ch.window_count !== oldest_low.window_count) begin
          $display("%0t window_count expected %0d actual %0d", $time,
                   oldest_low.window_count, result_ch.window_count);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    logic [SAMPLE_W-1:0] last_us;
    logic [SAMPLE_W-1:0] us;
    rst_n = 1'b0;

    // zero mean first, then rate extremes, equal samples and single high bits
    frames_to_send = '{20'd0, 20'd0, 20'd1, 20'd1, 20'd2, 20'hFFFFF, 20'hFFFFF,
                       20'h80000, 20'h7FFFF, 20'd16666, 20'd16666, 20'd16667,
                       20'd33333, 20'h55555, 20'hAAAAA, 20'd3};
    last_us = 20'd16666;
    for (int i = 0; i < N_RANDOM; i++) begin
      case ($urandom_range(0, 99)) inside
        [0:1]:   us = SAMPLE_W'($urandom_range(0, 20'hFFFFF));
        [2:10]:  us = SAMPLE_W'($urandom_range(20000, 250000));
        [11:13]: us = SAMPLE_W'($urandom_range(0, 3));
        [14:19]: us = last_us;
        default: us = SAMPLE_W'($urandom_range(6000, 34000));
      endcase
      frames_to_send.push_back(us);
      last_us = us;
    end
    frames_total = frames_to_send.size();

    repeat (7) @(posedge clk_i);
    rst_n <= 1'b1;

    while (frames_taken < frames_total) @(posedge clk_i);
    while (expected_lows.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0 && expected_lows.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
